@@ src/oms_pkg.sv @@
package oms_pkg;

  localparam int CAPACITY    = 1024;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 32;
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = ((FUNC_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STAT_W + KEY_W + 7) / 8) * 8;

  // cells per registered group of the answer reduction
  localparam int GRP_SIZE = 32;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MIN    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MAX    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_ABOVE  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CEIL   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_BELOW  = 3'd6;
  localparam logic [FUNC_W-1:0] FN_FLOOR  = 3'd7;

  localparam logic [STAT_W-1:0] STAT_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  // which per-cell flag the answer search walks along
  localparam logic [1:0] FLAG_NONE = 2'd0;
  localparam logic [1:0] FLAG_LT   = 2'd1;
  localparam logic [1:0] FLAG_LE   = 2'd2;
  localparam logic [1:0] FLAG_LIVE = 2'd3;

  typedef struct packed {
    logic       ins;
    logic       del;
    logic [1:0] flag_sel;
    logic       down;
  } cell_ctl_t;

endpackage

@@ src/oms_cell.sv @@
module oms_cell
  import oms_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic                    live,
  input  logic signed [KEY_W-1:0] key,
  input  logic                    left_le,
  input  logic signed [KEY_W-1:0] left_ent,
  input  logic                    left_f,
  input  logic signed [KEY_W-1:0] right_ent,
  input  logic                    right_f,
  output logic                    le,
  output logic signed [KEY_W-1:0] ent,
  output logic                    f,
  output logic                    hit,
  output logic        [KEY_W-1:0] hit_val,
  output logic                    eq
);

  logic signed [KEY_W-1:0] ent_r;
  logic signed [KEY_W-1:0] ent_nxt;
  logic                    lt_r;
  logic                    le_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins && !le_r) begin
      // first cell above the new value takes it, the rest move up one
      ent_nxt = left_le ? key : left_ent;
    end else if (ctl.del && !lt_r) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    lt_r  <= live && (ent_r < key);
    le_r  <= live && (ent_r <= key);
  end

  always_comb begin
    case (ctl.flag_sel)
      FLAG_LT:   f = lt_r;
      FLAG_LE:   f = le_r;
      FLAG_LIVE: f = live;
      default:   f = 1'b0;
    endcase
  end

  // up: first live cell past the flagged run, down: last flagged cell
  assign hit     = ctl.down ? (f && !right_f) : (live && !f && left_f);
  assign hit_val = hit ? ent_r : '0;
  assign eq      = le_r && !lt_r;
  assign le      = le_r;
  assign ent     = ent_r;

endmodule

@@ src/oms_reduce.sv @@
module oms_reduce
  import oms_pkg::*;
(
  input  logic                clk,
  input  logic [CAPACITY-1:0] hit,
  input  logic [CAPACITY-1:0] eq,
  input  logic [KEY_W-1:0]    hit_val [CAPACITY],
  output logic                any_hit,
  output logic                any_eq,
  output logic [KEY_W-1:0]    val
);

  logic [NUM_GRP-1:0] grp_hit_r;
  logic [NUM_GRP-1:0] grp_eq_r;
  logic [KEY_W-1:0]   grp_val_r [NUM_GRP];

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    localparam int LO  = g * GRP_SIZE;
    localparam int CNT = (CAPACITY - LO < GRP_SIZE) ? (CAPACITY - LO) : GRP_SIZE;

    logic             hit_nxt;
    logic             eq_nxt;
    logic [KEY_W-1:0] val_nxt;

    always_comb begin
      hit_nxt = 1'b0;
      eq_nxt  = 1'b0;
      val_nxt = '0;
      for (int j = 0; j < CNT; j++) begin
        hit_nxt = hit_nxt | hit[LO + j];
        eq_nxt  = eq_nxt | eq[LO + j];
        val_nxt = val_nxt | hit_val[LO + j];
      end
    end

    always_ff @(posedge clk) begin
      grp_hit_r[g] <= hit_nxt;
      grp_eq_r[g]  <= eq_nxt;
      grp_val_r[g] <= val_nxt;
    end
  end

  // at most one cell hits, so a plain or picks its entry
  always_comb begin
    val = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      val = val | grp_val_r[g];
    end
  end

  assign any_hit = |grp_hit_r;
  assign any_eq  = |grp_eq_r;

endmodule

@@ src/ordered_multiset_engine_unit.sv @@
// Sorted multiset of signed 32-bit values, up to CAPACITY entries.
// Input channel in_*: one request per accepted beat, carrying an operation
// code (insert, erase all equal, min, max, above, ceiling, below, floor)
// and a value. Output channel out_*: at most one result per request, a
// status and the answering entry (zero unless the status is found).
// Insert and erase give no result, except an insert into a full set,
// which is dropped and answered with status full.
// Every entry sits in a cell of a chain; all cells compare against the
// value at once and shift towards a neighbour on insert or erase.
// A request runs in steps: compare, a registered reduction over groups of
// cells, then update or answer; the result is loaded into the output
// register at the end of the last step, and the next request is taken after it.
// An erase repeats compare, reduce and shift once per removed copy.
// Reset empties the set at once (no clearing pass).
// A result waits in the output register until taken; the next request is
// accepted meanwhile and holds in its last step only if it has a result
// and the register is still full.
module ordered_multiset_engine_unit
  import oms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // func [2:0], key_value [34:3]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status [1:0], found_value [33:2]
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0]              state_r;
  logic [1:0]              state_nxt;
  logic [FUNC_W-1:0]       func_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;

  logic                    out_tvalid_r;
  logic                    out_tvalid_nxt;
  logic [STAT_W-1:0]       out_stat_r;
  logic [KEY_W-1:0]        out_val_r;

  logic                    in_fire;
  logic signed [KEY_W-1:0] in_key;
  logic signed [KEY_W-1:0] cmp_key;
  cell_ctl_t               ctl;
  logic                    produce;
  logic [STAT_W-1:0]       res_stat;
  logic [KEY_W-1:0]        res_val;
  logic                    can_out;
  logic                    empty;
  logic                    full;

  logic [CAPACITY-1:0]     live_w;
  logic [CAPACITY-1:0]     le_w;
  logic [CAPACITY-1:0]     f_w;
  logic [CAPACITY-1:0]     hit_w;
  logic [CAPACITY-1:0]     eq_w;
  logic signed [KEY_W-1:0] ent_w     [CAPACITY];
  logic [KEY_W-1:0]        hit_val_w [CAPACITY];

  logic                    any_hit;
  logic                    any_eq;
  logic [KEY_W-1:0]        red_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_key    = signed'(in_tdata[FUNC_W +: KEY_W]);
  assign cmp_key   = (state_r == S_IDLE) ? in_key : key_r;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign can_out   = !out_tvalid_r || out_tready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    l_le;
    logic signed [KEY_W-1:0] l_ent;
    logic                    l_f;
    logic signed [KEY_W-1:0] r_ent;
    logic                    r_f;

    assign live_w[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign l_le  = 1'b1;
      assign l_ent = '0;
      assign l_f   = 1'b1;
    end else begin : g_mid_l
      assign l_le  = le_w[i-1];
      assign l_ent = ent_w[i-1];
      assign l_f   = f_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_ent = '0;
      assign r_f   = 1'b0;
    end else begin : g_mid_r
      assign r_ent = ent_w[i+1];
      assign r_f   = f_w[i+1];
    end

    oms_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (live_w[i]),
      .key       (cmp_key),
      .left_le   (l_le),
      .left_ent  (l_ent),
      .left_f    (l_f),
      .right_ent (r_ent),
      .right_f   (r_f),
      .le        (le_w[i]),
      .ent       (ent_w[i]),
      .f         (f_w[i]),
      .hit       (hit_w[i]),
      .hit_val   (hit_val_w[i]),
      .eq        (eq_w[i])
    );
  end

  oms_reduce u_reduce (
    .clk     (clk),
    .hit     (hit_w),
    .eq      (eq_w),
    .hit_val (hit_val_w),
    .any_hit (any_hit),
    .any_eq  (any_eq),
    .val     (red_val)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    produce      = 1'b0;
    res_stat     = STAT_FOUND;
    res_val      = '0;
    ctl.ins      = 1'b0;
    ctl.del      = 1'b0;
    ctl.flag_sel = FLAG_NONE;
    ctl.down     = 1'b0;

    case (func_r)
      FN_MAX: begin
        ctl.flag_sel = FLAG_LIVE;
        ctl.down     = 1'b1;
      end
      FN_ABOVE: ctl.flag_sel = FLAG_LE;
      FN_CEIL:  ctl.flag_sel = FLAG_LT;
      FN_BELOW: begin
        ctl.flag_sel = FLAG_LT;
        ctl.down     = 1'b1;
      end
      FN_FLOOR: begin
        ctl.flag_sel = FLAG_LE;
        ctl.down     = 1'b1;
      end
      default: ctl.flag_sel = FLAG_NONE;
    endcase

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_RED;
        end
      end
      S_CMP:  state_nxt = S_RED;
      S_RED:  state_nxt = S_EXEC;
      S_EXEC: begin
        case (func_r)
          FN_INSERT: begin
            if (full) begin
              if (can_out) begin
                produce   = 1'b1;
                res_stat  = STAT_FULL;
                state_nxt = S_IDLE;
              end
            end else begin
              ctl.ins   = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              state_nxt = S_IDLE;
            end
          end
          FN_ERASE: begin
            // one copy per pass, then compare again
            if (any_eq) begin
              ctl.del   = 1'b1;
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_CMP;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (can_out) begin
              produce   = 1'b1;
              state_nxt = S_IDLE;
              if (empty) begin
                res_stat = STAT_EMPTY;
              end else if (any_hit) begin
                res_stat = STAT_FOUND;
                res_val  = red_val;
              end else begin
                res_stat = STAT_NONE;
              end
            end
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid_nxt = produce || (out_tvalid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_tdata[FUNC_W-1:0];
      key_r  <= in_key;
    end
    if (produce) begin
      out_stat_r <= res_stat;
      out_val_r  <= res_val;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - STAT_W - KEY_W){1'b0}}, out_val_r, out_stat_r};

endmodule

@@ src/oms_checker.sv @@
module oms_checker
  import oms_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata   // status [1:0], found_value [33:2]
);

  // a request keeps the input closed for its reduce and final steps
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input reopened too early after a request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STAT_W-1:0] != STAT_FOUND) |->
      (out_tdata[STAT_W +: KEY_W] == '0))
    else $error("value not zero on a miss status");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  // a result only appears at the end of a request's last step
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

endmodule

bind ordered_multiset_engine_unit oms_checker u_oms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
